/* src/bns_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bns_pkg;

  localparam int COORD_W  = 16;
  localparam int CLASS_W  = 8;
  localparam int TDATA_W  = 5 * COORD_W + CLASS_W;
  localparam int TUSER_W  = 2;
  localparam int AREA_W   = 2 * COORD_W;
  localparam int SPAN_W   = COORD_W + 2;
  localparam int PROD_W   = 2 * SPAN_W;
  localparam int LIMQ_W   = AREA_W + COORD_W;
  localparam int CMP_W    = PROD_W + COORD_W;

  localparam logic [COORD_W-1:0] LIMIT_RESET = 16'h8000;

  localparam logic REG_CONF    = 1'b0;
  localparam logic REG_OVERLAP = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic eval;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic best_found;
    logic cur_valid;
    logic out_free;
  } ctrl_status_t;

  function automatic logic [COORD_W:0] span_lo(input logic [COORD_W-1:0] c,
                                               input logic [COORD_W-1:0] s);
    logic [COORD_W:0] a;
    a = {c, 1'b0};
    return (a > {1'b0, s}) ? a - {1'b0, s} : '0;
  endfunction

  function automatic logic [SPAN_W-1:0] overlap2(input logic [COORD_W-1:0] c1,
                                                 input logic [COORD_W-1:0] s1,
                                                 input logic [COORD_W-1:0] c2,
                                                 input logic [COORD_W-1:0] s2);
    logic [SPAN_W-1:0] l1, h1, l2, h2, l, h;
    l1 = {1'b0, span_lo(c1, s1)};
    l2 = {1'b0, span_lo(c2, s2)};
    h1 = l1 + {1'b0, s1, 1'b0};
    h2 = l2 + {1'b0, s2, 1'b0};
    l = (l1 > l2) ? l1 : l2;
    h = (h1 < h2) ? h1 : h2;
    return (h > l) ? h - l : '0;
  endfunction

endpackage
`default_nettype wire

/* src/bns_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module bns_ram #(
  parameter int WIDTH = 88,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/bns_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module bns_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tlast,
  output logic                       s_tready,
  input  wire bns_pkg::ctrl_status_t st,
  output bns_pkg::ctrl_cmd_t         cmd
);
  import bns_pkg::*;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_A    = 3'd3;
  localparam logic [2:0] S_B    = 3'd4;
  localparam logic [2:0] S_C    = 3'd5;
  localparam logic [2:0] S_D    = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state, state_next;
  logic       fin_ok;

  assign s_tready = (state == S_LOAD);
  assign fin_ok   = st.out_free || (!st.cur_valid && st.best_found);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.load      = (state == S_LOAD) && s_tvalid;
    cmd.scan_init = (state == S_INIT);
    cmd.eval      = (state == S_D);
    cmd.finish    = (state == S_FIN) && fin_ok;
    case (state)
      S_LOAD: begin
        if (s_tvalid && s_tlast) state_next = S_INIT;
      end
      S_INIT: state_next = S_RD;
      S_RD: begin
        state_next = st.scan_done ? S_FIN : S_A;
      end
      S_A: state_next = S_B;
      S_B: state_next = S_C;
      S_C: state_next = S_D;
      S_D: state_next = S_RD;
      S_FIN: begin
        if (fin_ok) state_next = st.best_found ? S_INIT : S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* src/bns_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module bns_datapath #(
  parameter int MAX_BOXES  = 64,
  parameter int CLASS_BITS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [bns_pkg::TDATA_W-1:0]  s_tdata,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [bns_pkg::COORD_W-1:0]  cfg_data,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [bns_pkg::TDATA_W-1:0]       m_tdata,
  output logic [bns_pkg::TUSER_W-1:0]       m_tuser,
  output logic                              m_tlast,
  input  wire bns_pkg::ctrl_cmd_t           cmd,
  output bns_pkg::ctrl_status_t             st
);
  import bns_pkg::*;

  localparam int IW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int CB = (CLASS_BITS < CLASS_W) ? CLASS_BITS : CLASS_W;
  localparam int DW = 5 * COORD_W + CB;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BOXES);

  logic [CW-1:0]      count, idx;
  logic               ovf;
  logic [MAX_BOXES-1:0] mask;
  logic [COORD_W-1:0] conf_lim, ov_lim;
  logic               best_found, cur_valid;
  logic [IW-1:0]      best_idx;
  logic [DW-1:0]      best_data, cur_data, wdata, rdata;
  logic [AREA_W-1:0]  best_area, cur_area;
  logic [SPAN_W-1:0]  iw_a, ih_a;
  logic [AREA_W-1:0]  a2_a, a2_b, a2_c, amin_b;
  logic [PROD_W-1:0]  p_b, p_c;
  logic [LIMQ_W-1:0]  q_c;
  logic               zero_b, zero_c;
  logic               sup, ram_we;
  logic [CMP_W-1:0]   lhs, rhs;
  logic [COORD_W-1:0] r_score, b_score;
  logic [CLASS_W-1:0] cls_in, cls_out;

  assign cls_in = s_tdata[5*COORD_W +: CLASS_W];
  assign wdata  = {cls_in[CB-1:0], s_tdata[5*COORD_W-1:0]};
  assign ram_we = cmd.load && (count < MAX_CNT);

  bns_ram #(.WIDTH(DW), .DEPTH(MAX_BOXES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IW-1:0]),
    .wdata (wdata),
    .raddr (idx[IW-1:0]),
    .rdata (rdata)
  );

  assign r_score = rdata[4*COORD_W +: COORD_W];
  assign b_score = best_data[4*COORD_W +: COORD_W];

  always_ff @(posedge clk) begin
    iw_a   <= overlap2(cur_data[0 +: COORD_W], cur_data[2*COORD_W +: COORD_W],
                       rdata[0 +: COORD_W], rdata[2*COORD_W +: COORD_W]);
    ih_a   <= overlap2(cur_data[COORD_W +: COORD_W], cur_data[3*COORD_W +: COORD_W],
                       rdata[COORD_W +: COORD_W], rdata[3*COORD_W +: COORD_W]);
    a2_a   <= rdata[2*COORD_W +: COORD_W] * rdata[3*COORD_W +: COORD_W];
    p_b    <= iw_a * ih_a;
    zero_b <= (iw_a == '0) || (ih_a == '0);
    amin_b <= (cur_area < a2_a) ? cur_area : a2_a;
    a2_b   <= a2_a;
    q_c    <= amin_b * ov_lim;
    p_c    <= p_b;
    zero_c <= zero_b;
    a2_c   <= a2_b;
  end

  assign lhs = {p_c, {COORD_W{1'b0}}};
  assign rhs = CMP_W'({q_c, 2'b00});
  assign sup = cur_valid && !zero_c && (lhs > rhs);

  assign st.scan_done  = (idx == count);
  assign st.best_found = best_found;
  assign st.cur_valid  = cur_valid;
  assign st.out_free   = !m_tvalid || m_tready;

  always_comb begin
    cls_out         = '0;
    cls_out[CB-1:0] = cur_data[5*COORD_W +: CB];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conf_lim <= LIMIT_RESET;
      ov_lim   <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONF:    conf_lim <= cfg_data;
        REG_OVERLAP: ov_lim   <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      ovf        <= 1'b0;
      mask       <= '0;
      idx        <= '0;
      best_found <= 1'b0;
      cur_valid  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.finish && (cur_valid || !best_found)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.load) begin
        if (count < MAX_CNT) count <= count + 1'b1;
        else ovf <= 1'b1;
      end
      if (cmd.scan_init) begin
        idx        <= '0;
        best_found <= 1'b0;
      end
      if (cmd.eval) begin
        idx <= idx + 1'b1;
        if (!mask[idx[IW-1:0]]) begin
          if (sup) begin
            mask[idx[IW-1:0]] <= 1'b1;
          end else if (r_score >= conf_lim && (!best_found || r_score > b_score)) begin
            best_found <= 1'b1;
            best_idx   <= idx[IW-1:0];
            best_data  <= rdata;
            best_area  <= a2_c;
          end
        end
      end
      if (cmd.finish) begin
        if (cur_valid || !best_found) begin
          m_tlast  <= !best_found;
          m_tuser  <= {ovf, cur_valid};
          m_tdata  <= cur_valid ? {cls_out, cur_data[5*COORD_W-1:0]} : '0;
        end
        if (best_found) begin
          cur_valid          <= 1'b1;
          cur_data           <= best_data;
          cur_area           <= best_area;
          mask[best_idx]     <= 1'b1;
        end else begin
          count     <= '0;
          ovf       <= 1'b0;
          mask      <= '0;
          cur_valid <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* src/box_nonmax_suppression.sv */
// Greedy non-maximum suppression over a set of up to MAX_BOXES boxes.
// Input words arrive on s_t*: one box per word, tlast closes the set.
// Loading takes one word per cycle; boxes beyond MAX_BOXES are dropped
// and reported through the overflowed flag of the results.
// After the last word the block stops taking words and runs selection
// rounds over its box memory. Each round reads every stored box once,
// one at a time through the overlap test states S_RD, S_A, S_B, S_C, S_D;
// loading resumes after the round that finds no further kept box. Each
// round finds the next kept box by descending score among boxes at or
// above the confidence limit and suppresses every remaining box whose
// overlap with the current one exceeds the overlap limit times the smaller area.
// Results leave on m_t* from an output register, one word per kept box,
// with tlast on the final one; a set with no kept box yields a single
// word with box_valid low. When the receiver stalls, the rounds wait
// with the pending result held. Reset is synchronous; it clears the
// control state, restores both limits to one half and leaves the box
// memory undefined, which needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module box_nonmax_suppression #(
  parameter int MAX_BOXES  = 64,
  parameter int CLASS_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // center_x, center_y, box_width, box_height, score, class_id
  input  wire logic [bns_pkg::TDATA_W-1:0] s_tdata,
  input  wire logic                        s_tlast,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // out_center_x, out_center_y, out_width, out_height, out_score, out_class
  output logic [bns_pkg::TDATA_W-1:0]      m_tdata,
  // box_valid, overflowed
  output logic [bns_pkg::TUSER_W-1:0]      m_tuser,
  output logic                             m_tlast,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [bns_pkg::COORD_W-1:0] cfg_data
);
  import bns_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t st;

  bns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  bns_datapath #(.MAX_BOXES(MAX_BOXES), .CLASS_BITS(CLASS_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .st        (st)
  );

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("result without a box is not the last of its set");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("result without a box carries box fields");

  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken right after the last word of a set");

endmodule
`default_nettype wire
